[hw/rtl/vsl_pkg.sv]
// ----------------------------------------------------------------------------
// vsl_pkg
// Shared constants, stage bundles and the fractional power table of the
// vertex smooth light pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vsl_pkg;

  localparam int unsigned LIGHT_W   = 4;
  localparam int unsigned HEIGHT_W  = 8;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned PROD_W    = 15;  // positive a*b never exceeds 60*512
  localparam int unsigned WQ_W      = 13;  // exponent numerator after the >>25
  localparam int unsigned K8_W      = 10;  // exponent in q.8, at most about 709
  localparam int unsigned POW_W     = 17;  // q16 value, up to and including 1.0

  localparam logic [LEVEL_W-1:0] WATER_RESET = 8'd64;

  // -log2(0.88) in q24
  localparam logic [21:0] LOG2_INV_088 = 22'd3094131;
  localparam int unsigned EXP_SHIFT    = 25;
  localparam int unsigned CNT_BIAS_SH  = 24;

  // floor(w/3) = (w*2731) >> 13 for every w below 4096
  localparam logic [11:0] RECIP3       = 12'd2731;
  localparam int unsigned RECIP3_SH    = 13;

  localparam logic [7:0] SHADE_SCALE   = 8'd230;
  localparam logic [7:0] SHADE_BIAS    = 8'd25;
  localparam logic [7:0] SHADE_MAX     = 8'd255;
  localparam logic [7:0] SHADE_DARK    = 8'd0;

  // 2^-(2^-i) in q16 for i = 1..8
  localparam logic [15:0] POW2_FRAC [8] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757,
    16'd64132, 16'd64830, 16'd65182, 16'd65359
  };

  typedef logic [POW_W-1:0] pow_tbl_t [256];

  // 2^-(f/256) in q16, one rounded product per set fraction bit
  function automatic pow_tbl_t build_pow_tbl();
    pow_tbl_t    tbl;
    logic [33:0] acc;
    for (int i = 0; i < 256; i++) begin
      acc = 34'd65536;
      for (int j = 0; j < 8; j++) begin
        if (((i >> (7 - j)) & 1) != 0) begin
          acc = ({17'd0, acc[16:0]} * {18'd0, POW2_FRAC[j]} + 34'd32768) >> 16;
        end
      end
      tbl[i] = acc[POW_W-1:0];
    end
    return tbl;
  endfunction

  localparam pow_tbl_t POW_TBL = build_pow_tbl();

  // after the a*b product stage
  typedef struct packed {
    logic              none;  // no transparent corner
    logic              sat;   // exponent not positive
    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] prod;
  } vsl_prod_t;

  // after the exponent stages
  typedef struct packed {
    logic            none;
    logic            sat;
    logic [K8_W-1:0] k8;
  } vsl_expo_t;

endpackage

`default_nettype wire

[hw/rtl/vsl_front.sv]
// ----------------------------------------------------------------------------
// vsl_front
// Counts the transparent corners, sums their light and forms the signed
// exponent numerator (15t - V) * (512 - 3*min(height, water_level)).
// ----------------------------------------------------------------------------
`default_nettype none

module vsl_front
  import vsl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_valid,
  input  wire logic [LIGHT_W-1:0]  light_a,
  input  wire logic [LIGHT_W-1:0]  light_b,
  input  wire logic [LIGHT_W-1:0]  light_c,
  input  wire logic [LIGHT_W-1:0]  light_d,
  input  wire logic                open_a,
  input  wire logic                open_b,
  input  wire logic                open_c,
  input  wire logic                open_d,
  input  wire logic [HEIGHT_W-1:0] height,
  input  wire logic [LEVEL_W-1:0]  water_level,
  output logic                     prod_valid,
  output vsl_prod_t                prod
);

  logic [CNT_W-1:0]      cnt_nxt;
  logic [5:0]            sum_nxt;
  logic [HEIGHT_W-1:0]   lvl_min;
  logic [9:0]            lvl_x3;
  logic [6:0]            cnt_x15;
  logic [6:0]            diff;
  logic signed [10:0]    b_nxt;

  logic                  a_valid_r;
  logic [5:0]            a_r;
  logic signed [10:0]    b_r;
  logic [CNT_W-1:0]      cnt_r;

  logic signed [17:0]    mul;
  logic                  prod_valid_r;
  vsl_prod_t             prod_r;
  vsl_prod_t             prod_nxt;

  always_comb begin
    cnt_nxt = {2'b00, open_a} + {2'b00, open_b} + {2'b00, open_c} + {2'b00, open_d};
    sum_nxt = (open_a ? {2'b00, light_a} : 6'd0) + (open_b ? {2'b00, light_b} : 6'd0)
            + (open_c ? {2'b00, light_c} : 6'd0) + (open_d ? {2'b00, light_d} : 6'd0);
    lvl_min = (height < water_level) ? height : water_level;
    lvl_x3  = {2'b00, lvl_min} + {1'b0, lvl_min, 1'b0};
    b_nxt   = $signed(11'd512) - $signed({1'b0, lvl_x3});
    cnt_x15 = {cnt_nxt, 4'b0000} - {4'b0000, cnt_nxt};
    diff    = cnt_x15 - {1'b0, sum_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
    if (adv) begin
      a_r   <= diff[5:0];
      b_r   <= b_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign mul = $signed({1'b0, a_r}) * b_r;

  always_comb begin
    prod_nxt.none = (cnt_r == '0);
    prod_nxt.sat  = mul[17] || (mul == '0);
    prod_nxt.cnt  = cnt_r;
    prod_nxt.prod = mul[PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (adv) begin
      prod_valid_r <= a_valid_r;
    end
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

endmodule

`default_nettype wire

[hw/rtl/vsl_expo.sv]
// ----------------------------------------------------------------------------
// vsl_expo
// Scales the numerator by -log2(0.88) and divides by the corner count,
// giving the base-2 exponent k in q.8, rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module vsl_expo
  import vsl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic       prod_valid,
  input  vsl_prod_t       prod,
  output logic            expo_valid,
  output vsl_expo_t       expo
);

  localparam int unsigned X_W = 38;

  logic [X_W-1:0]       x_full;
  logic                 w_valid_r;
  logic [WQ_W-1:0]      w_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 none_r;
  logic                 sat_r;

  logic [24:0]          w_div3;
  logic [K8_W-1:0]      k8_nxt;
  logic                 expo_valid_r;
  vsl_expo_t            expo_r;

  // n*L + t*2^24, the rounding half of t*2^25
  assign x_full = {{(X_W-PROD_W){1'b0}}, prod.prod} * {{(X_W-22){1'b0}}, LOG2_INV_088}
                + ({{(X_W-CNT_W){1'b0}}, prod.cnt} << CNT_BIAS_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
    end else if (adv) begin
      w_valid_r <= prod_valid;
    end
    if (adv) begin
      w_r    <= x_full[EXP_SHIFT +: WQ_W];
      cnt_r  <= prod.cnt;
      none_r <= prod.none;
      sat_r  <= prod.sat;
    end
  end

  assign w_div3 = {12'd0, w_r} * {13'd0, RECIP3};

  always_comb begin
    case (cnt_r)
      3'd1:    k8_nxt = w_r[K8_W-1:0];
      3'd2:    k8_nxt = w_r[K8_W:1];
      3'd3:    k8_nxt = w_div3[RECIP3_SH +: K8_W];
      3'd4:    k8_nxt = w_r[K8_W+1:2];
      default: k8_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expo_valid_r <= 1'b0;
    end else if (adv) begin
      expo_valid_r <= w_valid_r;
    end
    if (adv) begin
      expo_r.none <= none_r;
      expo_r.sat  <= sat_r;
      expo_r.k8   <= k8_nxt;
    end
  end

  assign expo_valid = expo_valid_r;
  assign expo       = expo_r;

endmodule

`default_nettype wire

[hw/rtl/vsl_pow.sv]
// ----------------------------------------------------------------------------
// vsl_pow
// Evaluates 2^-k from the fraction table and an integer shift, then maps
// it onto the 25..255 brightness range and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vsl_pow
  import vsl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        expo_valid,
  input  vsl_expo_t        expo,
  output logic             out_valid,
  output logic [7:0]       out_vertex_light
);

  logic [POW_W-1:0] p_nxt;
  logic             p_valid_r;
  logic [POW_W-1:0] p_r;
  logic             none_r;
  logic             sat_r;

  logic [24:0]      scaled;
  logic [8:0]       shade;
  logic [7:0]       light_nxt;
  logic             out_valid_r;
  logic [7:0]       out_vertex_light_r;

  assign p_nxt = POW_TBL[expo.k8[7:0]] >> expo.k8[K8_W-1:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= expo_valid;
    end
    if (adv) begin
      p_r    <= p_nxt;
      none_r <= expo.none;
      sat_r  <= expo.sat;
    end
  end

  assign scaled = {8'd0, p_r} * {17'd0, SHADE_SCALE};
  // scaled top bits stay at or below 230, so the sum fits in eight bits
  assign shade  = {1'b0, SHADE_BIAS} + scaled[24:16];

  always_comb begin
    if (none_r) begin
      light_nxt = SHADE_DARK;
    end else if (sat_r) begin
      light_nxt = SHADE_MAX;
    end else begin
      light_nxt = shade[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p_valid_r;
    end
    if (adv) begin
      out_vertex_light_r <= light_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_light = out_vertex_light_r;

endmodule

`default_nettype wire

[hw/rtl/vertex_smooth_light_core.sv]
// ----------------------------------------------------------------------------
// vertex_smooth_light_core
// Smooth vertex lighting: averages the light of the transparent corner
// cells and shades it as 25 + 230*0.88^((15-lv)*depth factor).
//
// Usage:
//   in_*   : one vertex per beat (four light levels, four transparency
//            flags, height). Taken when in_valid is high and in_stall low.
//   out_*  : one brightness per beat, taken when out_valid is high and
//            out_stall low.
//   cfg_*  : water_level write; cfg_ready is always high. Write only while
//            the pipeline is empty.
//   One vertex enters every cycle while the output is not stalled. Six
//   register stages: corner count and sum, the a*b product, the
//   -log2(0.88) multiply, the divide by corner count, the power table
//   lookup and the final scale into the output register.
//   When out_stall holds a waiting result, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset empties the pipeline and sets water_level to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_smooth_light_core
  import vsl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [LIGHT_W-1:0]  in_light_a,
  input  wire logic [LIGHT_W-1:0]  in_light_b,
  input  wire logic [LIGHT_W-1:0]  in_light_c,
  input  wire logic [LIGHT_W-1:0]  in_light_d,
  input  wire logic                in_open_a,
  input  wire logic                in_open_b,
  input  wire logic                in_open_c,
  input  wire logic                in_open_d,
  input  wire logic [HEIGHT_W-1:0] in_height,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_vertex_light,

  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [LEVEL_W-1:0]  cfg_water_level
);

  logic               adv;
  logic [LEVEL_W-1:0] water_level_r;
  logic               prod_valid;
  vsl_prod_t          prod;
  logic               expo_valid;
  vsl_expo_t          expo;

  // freeze every stage while a finished beat waits at the output
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_level_r <= WATER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      water_level_r <= cfg_water_level;
    end
  end

  vsl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .light_a     (in_light_a),
    .light_b     (in_light_b),
    .light_c     (in_light_c),
    .light_d     (in_light_d),
    .open_a      (in_open_a),
    .open_b      (in_open_b),
    .open_c      (in_open_c),
    .open_d      (in_open_d),
    .height      (in_height),
    .water_level (water_level_r),
    .prod_valid  (prod_valid),
    .prod        (prod)
  );

  vsl_expo u_expo (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .prod_valid (prod_valid),
    .prod       (prod),
    .expo_valid (expo_valid),
    .expo       (expo)
  );

  vsl_pow u_pow (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .expo_valid       (expo_valid),
    .expo             (expo),
    .out_valid        (out_valid),
    .out_vertex_light (out_vertex_light)
  );

endmodule

`default_nettype wire
